[rtl/atq_pkg.sv]
// Shared types and codes for the allocation tracker with quarantine.
package atq_pkg;

  localparam int unsigned CntW = 32;
  localparam logic [CntW-1:0] CntMax = '1;
  localparam logic [15:0] ThreshReset = 16'd100;

  typedef enum logic [2:0] {
    FN_ALLOC  = 3'd0,
    FN_ZFREE  = 3'd1,
    FN_PFREE  = 3'd2,
    FN_UNTRK  = 3'd3,
    FN_CLEAR  = 3'd4
  } func_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_FULL   = 3'd1,
    ST_UNKNOWN = 3'd2,
    ST_WILD   = 3'd3,
    ST_DOUBLE = 3'd4,
    ST_CONF   = 3'd5
  } status_t;

  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
    sat_inc = (v == CntMax) ? v : v + 1'b1;
  endfunction

endpackage

[rtl/atq_if.sv]
// Valid/ready channel interfaces for requests, results and configuration.
interface atq_req_if #(parameter int ADDR_BITS = 48) ();
  logic                 valid;
  logic                 ready;
  logic [2:0]           func;
  logic [ADDR_BITS-1:0] addr;
  logic [15:0]          zone_id;
  logic [31:0]          alloc_size;
  modport source (output valid, func, addr, zone_id, alloc_size, input ready);
  modport sink (input valid, func, addr, zone_id, alloc_size, output ready);
endinterface

interface atq_rsp_if #(parameter int ADDR_BITS = 48) ();
  logic                 valid;
  logic                 ready;
  logic [2:0]           status;
  logic                 release_valid;
  logic [ADDR_BITS-1:0] release_addr;
  logic [31:0]          release_size;
  logic [31:0]          allocations_seen;
  logic [31:0]          frees_seen;
  logic [31:0]          double_frees;
  logic [31:0]          zone_confusions;
  logic [31:0]          wild_frees;
  modport source (output valid, status, release_valid, release_addr, release_size,
                  allocations_seen, frees_seen, double_frees, zone_confusions,
                  wild_frees, input ready);
  modport sink (input valid, status, release_valid, release_addr, release_size,
                allocations_seen, frees_seen, double_frees, zone_confusions,
                wild_frees, output ready);
endinterface

interface atq_cfg_if ();
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

[rtl/allocation_tracker_quarantine_unit.sv]
// Top level: hash table and quarantine ring held in memories, driven by a sequencer.
//
//   channel  role  contents
//   req      sink  func, addr, zone_id, alloc_size
//   rsp      src   status, release info, five counters
//   cfg      sink  wild_free_threshold
//
// Each probe step is a memory read, then a compare; a free that evicts the oldest ring
// entry also probes the table for the evicted address to untrack it. Each lookup stops
// after at most PROBE_LIMIT probes.
// After reset, and after a clear, a sweep over every table slot and ring entry empties
// the memories; no request is taken meanwhile. A stalled result holds the block.
module allocation_tracker_quarantine_unit #(
  parameter int TABLE_SLOTS = 8192,
  parameter int RING_DEPTH  = 4096,
  parameter int PROBE_LIMIT = 64,
  parameter int ADDR_BITS   = 48
) (
  input logic clk,
  input logic rst,
  atq_req_if.sink   req,
  atq_rsp_if.source rsp,
  atq_cfg_if.sink   cfg
);

  localparam int SW = $clog2(TABLE_SLOTS);
  localparam int RW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int PW = $clog2(PROBE_LIMIT + 1);
  localparam int CW = (SW > RW) ? SW + 1 : RW + 1;
  localparam int FW = $clog2(RING_DEPTH + 1);
  localparam logic [CW-1:0] SweepLast =
    CW'(((TABLE_SLOTS > RING_DEPTH) ? TABLE_SLOTS : RING_DEPTH) - 1);

  typedef struct packed {
    logic [ADDR_BITS-1:0] key;
    logic [15:0]          zone;
    logic [31:0]          size;
    logic                 freed;
  } slot_t;
  typedef struct packed {
    logic [ADDR_BITS-1:0] addr;
    logic [31:0]          size;
  } ring_t;

  typedef enum logic [3:0] {
    S_SWEEP, S_IDLE, S_PRD, S_PCHK, S_ERD, S_ECHK, S_OUT
  } state_t;

  slot_t tbl [TABLE_SLOTS];
  ring_t rng [RING_DEPTH];
  slot_t tbl_q;
  ring_t rng_q;

  state_t state;
  logic [CW-1:0] sweep;
  logic [15:0] thresh;
  logic [2:0] func;
  logic [ADDR_BITS-1:0] addr, ev_addr;
  logic [15:0] zone;
  logic [31:0] size;
  logic [SW-1:0] slot;
  logic [PW-1:0] probe;
  logic [RW-1:0] head;
  logic [FW-1:0] fill;
  logic [31:0] c_alloc, c_free, c_dbl, c_conf, c_wild;
  logic [2:0] status;
  logic rel;
  logic [ADDR_BITS-1:0] rel_addr;
  logic [31:0] rel_size;

  // Memory write port and read address, driven by the sequencer.
  logic tbl_we, rng_we;
  logic [SW-1:0] tbl_wa, tbl_ra;
  slot_t tbl_wd;
  ring_t rng_wd;
  logic [RW-1:0] rng_wa;

  function automatic logic [SW-1:0] home(input logic [ADDR_BITS-1:0] a);
    logic [ADDR_BITS-1:0] h;
    h = (a >> 4) ^ (a >> 18);
    home = h[SW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (tbl_we) tbl[tbl_wa] <= tbl_wd;
    tbl_q <= tbl[tbl_ra];
    if (rng_we) rng[rng_wa] <= rng_wd;
    rng_q <= rng[head];
  end

  logic hit, empty, last;
  assign hit   = (tbl_q.key == addr);
  assign empty = (tbl_q.key == '0);
  assign last  = (probe == PW'(PROBE_LIMIT - 1));

  always_comb begin
    tbl_we = 1'b0;
    tbl_wa = slot;
    tbl_wd = tbl_q;
    tbl_ra = slot;
    rng_we = 1'b0;
    rng_wa = head;
    rng_wd = '{addr: addr, size: tbl_q.size};
    unique case (state)
      S_SWEEP: begin
        tbl_we = 1'b1;
        tbl_wa = sweep[SW-1:0];
        tbl_wd = '0;
        rng_we = 1'b1;
        rng_wa = sweep[RW-1:0];
        rng_wd = '0;
      end
      S_IDLE: tbl_ra = home(req.addr);
      S_PCHK: begin
        if (func == atq_pkg::FN_ALLOC && (hit || empty)) begin
          tbl_we = 1'b1;
          tbl_wd = '{key: addr, zone: zone, size: size, freed: 1'b0};
        end else if (func == atq_pkg::FN_UNTRK && hit) begin
          tbl_we = 1'b1;
          tbl_wd.key = '0;
        end else if (hit && !(func == atq_pkg::FN_ZFREE && tbl_q.freed)) begin
          tbl_we = 1'b1;
          tbl_wd.freed = 1'b1;
          rng_we = 1'b1;
        end
      end
      S_ECHK: begin
        tbl_ra = slot;
        if (tbl_q.key == ev_addr) begin
          tbl_we = 1'b1;
          tbl_wd.key = '0;
        end
      end
      default: ;
    endcase
  end

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign rsp.valid = (state == S_OUT);
  assign rsp.status = status;
  assign rsp.release_valid = rel;
  assign rsp.release_addr = rel ? rel_addr : '0;
  assign rsp.release_size = rel ? rel_size : '0;
  assign rsp.allocations_seen = c_alloc;
  assign rsp.frees_seen = c_free;
  assign rsp.double_frees = c_dbl;
  assign rsp.zone_confusions = c_conf;
  assign rsp.wild_frees = c_wild;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_SWEEP;
      sweep <= '0;
      thresh <= atq_pkg::ThreshReset;
      func <= atq_pkg::FN_ALLOC;
      head <= '0;
      fill <= '0;
      c_alloc <= '0;
      c_free <= '0;
      c_dbl <= '0;
      c_conf <= '0;
      c_wild <= '0;
      rel <= 1'b0;
      status <= atq_pkg::ST_OK;
    end else begin
      if (cfg.valid) thresh <= cfg.data;
      unique case (state)
        S_SWEEP: begin
          sweep <= sweep + 1'b1;
          if (sweep == SweepLast) begin
            sweep <= '0;
            state <= (func == atq_pkg::FN_CLEAR) ? S_OUT : S_IDLE;
          end
        end
        S_IDLE: if (req.valid) begin
          func <= req.func;
          addr <= req.addr;
          zone <= req.zone_id;
          size <= req.alloc_size;
          slot <= home(req.addr);
          probe <= '0;
          rel <= 1'b0;
          status <= atq_pkg::ST_OK;
          if (req.func == atq_pkg::FN_CLEAR) begin
            head <= '0;
            fill <= '0;
            c_alloc <= '0;
            c_free <= '0;
            state <= S_SWEEP;
          end else if (req.func <= atq_pkg::FN_UNTRK && req.addr != '0) begin
            if (req.func == atq_pkg::FN_ALLOC) c_alloc <= atq_pkg::sat_inc(c_alloc);
            state <= S_PRD;
          end else begin
            func <= atq_pkg::FN_ALLOC;
            state <= S_OUT;
          end
        end
        S_PRD: state <= S_PCHK;
        S_PCHK: begin
          slot <= slot + 1'b1;
          probe <= probe + 1'b1;
          state <= S_PRD;
          if (func == atq_pkg::FN_ALLOC) begin
            if (hit || empty) state <= S_OUT;
            else if (last) begin
              status <= atq_pkg::ST_FULL;
              state <= S_OUT;
            end
          end else if (func == atq_pkg::FN_UNTRK) begin
            if (hit || empty || last) state <= S_OUT;
          end else if (hit) begin
            slot <= slot;
            if (func == atq_pkg::FN_ZFREE && tbl_q.freed) begin
              c_dbl <= atq_pkg::sat_inc(c_dbl);
              status <= atq_pkg::ST_DOUBLE;
              rel <= 1'b1;
              rel_addr <= addr;
              rel_size <= tbl_q.size;
              state <= S_OUT;
            end else begin
              if (tbl_q.freed) begin
                c_dbl <= atq_pkg::sat_inc(c_dbl);
                status <= atq_pkg::ST_DOUBLE;
              end else if (func == atq_pkg::FN_ZFREE && tbl_q.zone != '0 &&
                           zone != '0 && tbl_q.zone != zone) begin
                c_conf <= atq_pkg::sat_inc(c_conf);
                status <= atq_pkg::ST_CONF;
              end
              c_free <= atq_pkg::sat_inc(c_free);
              // rng_q holds the old head entry read while probing.
              ev_addr <= rng_q.addr;
              head <= (head == RW'(RING_DEPTH - 1)) ? '0 : head + 1'b1;
              if (fill == FW'(RING_DEPTH) && rng_q.addr != '0) begin
                rel <= 1'b1;
                rel_addr <= rng_q.addr;
                rel_size <= rng_q.size;
                slot <= home(rng_q.addr);
                probe <= '0;
                state <= S_ERD;
              end else begin
                if (fill != FW'(RING_DEPTH)) fill <= fill + 1'b1;
                state <= S_OUT;
              end
            end
          end else if (empty || last) begin
            status <= atq_pkg::ST_UNKNOWN;
            if (func == atq_pkg::FN_ZFREE && c_alloc > 32'(thresh)) begin
              c_wild <= atq_pkg::sat_inc(c_wild);
              status <= atq_pkg::ST_WILD;
            end
            rel <= 1'b1;
            rel_addr <= addr;
            rel_size <= '0;
            state <= S_OUT;
          end
        end
        S_ERD: state <= S_ECHK;
        S_ECHK: begin
          slot <= slot + 1'b1;
          probe <= probe + 1'b1;
          if (tbl_q.key == ev_addr || tbl_q.key == '0 || last) state <= S_OUT;
          else state <= S_ERD;
        end
        S_OUT: if (rsp.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) fill <= FW'(RING_DEPTH))
    else $error("ring fill beyond depth");
  assert property (@(posedge clk) disable iff (rst) rsp.valid |-> !req.ready)
    else $error("request taken while result pending");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && !rsp.ready) |=> state == S_OUT)
    else $error("result dropped under stall");
  assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.release_valid |-> rsp.release_addr != '0)
    else $error("release of null address");

endmodule
